// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by srtf_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SRTF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srtf check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SRTF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srtf check failed");

`endif

// ----- hw/rtl/srtf_pkg.sv -----
package srtf_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int DURATION_BITS = 16;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef logic [DURATION_BITS-1:0] rem_t;

	typedef struct packed {
		logic [7:0] id;
		logic [5:0] user;
		rem_t       rem;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   pop;
		logic   dec;
		entry_t new_ent;
	} cell_ctl_t;

	typedef struct packed {
		logic        running_valid;
		logic [7:0]  running_job;
		logic [31:0] tick_time;
		logic        finished_valid;
		logic [5:0]  finished_user;
		logic [31:0] finish_time;
		logic        overflow;
	} result_t;

endpackage

// ----- hw/rtl/srtf_in_if.sv -----
interface srtf_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  job_id;
	logic [5:0]  user_id;
	logic [15:0] job_duration;

	modport source (output valid, command, job_id, user_id, job_duration, input ready);
	modport sink (input valid, command, job_id, user_id, job_duration, output ready);
endinterface

// ----- hw/rtl/srtf_out_if.sv -----
interface srtf_out_if;
	logic        valid;
	logic        ready;
	logic        running_valid;
	logic [7:0]  running_job;
	logic [31:0] tick_time;
	logic        finished_valid;
	logic [5:0]  finished_user;
	logic [31:0] finish_time;
	logic        overflow;

	modport source (
		output valid, running_valid, running_job, tick_time, finished_valid,
			finished_user, finish_time, overflow,
		input ready
	);
	modport sink (
		input valid, running_valid, running_job, tick_time, finished_valid,
			finished_user, finish_time, overflow,
		output ready
	);
endinterface

// ----- hw/rtl/srtf_cell.sv -----
module srtf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  srtf_pkg::cell_ctl_t ctl,
	input  logic               left_keep,
	input  logic               left_valid,
	input  srtf_pkg::entry_t   left_ent,
	input  logic               right_valid,
	input  srtf_pkg::entry_t   right_ent,
	output logic               valid,
	output logic               keep,
	output srtf_pkg::entry_t   ent
);
	import srtf_pkg::*;

	logic   valid_q;
	entry_t ent_q;

	// entry stays in place on insert when it is not longer than the new job
	assign keep  = valid_q && (ent_q.rem <= ctl.new_ent.rem);
	assign valid = valid_q;
	assign ent   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end else if (ctl.insert && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			ent_q <= right_ent;
		end else if (ctl.insert && !keep) begin
			ent_q <= left_keep ? ctl.new_ent : left_ent;
		end else if (ctl.dec) begin
			ent_q.rem <= ent_q.rem - rem_t'(1);
		end
	end
endmodule

// ----- hw/rtl/shortest_remaining_time_scheduler_top.sv -----
// channel     dir  handshake      payload
// job_in      in   valid/ready    command, job_id, user_id, job_duration
// result_out  out  valid/ready    running/finished fields, tick_time, overflow
//
// one item per cycle while job_in.ready is high: the row of cells updates in the cycle the item transfers
// the result is registered and shows in the cycle after the input transfer
// job_in.ready is high while the result register is empty or being taken
// reset empties the row and the result register and clears the time counter

module shortest_remaining_time_scheduler_top (
	input logic        clk,
	input logic        arst_n,
	srtf_in_if.sink    job_in,
	srtf_out_if.source result_out
);
	import srtf_pkg::*;

	logic        out_valid_q;
	result_t     res_q;
	result_t     res_d;
	logic [31:0] time_q;

	logic   accept, full, empty, is_arrive, is_tick, insert, run, pop;
	rem_t   dur;
	entry_t new_ent;

	logic      valid [QUEUE_DEPTH];
	logic      keep  [QUEUE_DEPTH];
	entry_t    ent   [QUEUE_DEPTH];
	cell_ctl_t ctl   [QUEUE_DEPTH];

	assign job_in.ready = !out_valid_q || result_out.ready;
	assign accept       = job_in.valid && job_in.ready;

	assign dur       = job_in.job_duration[DURATION_BITS-1:0];
	assign full      = valid[QUEUE_DEPTH-1];
	assign empty     = !valid[0];
	assign is_arrive = accept && (job_in.command == CMD_ARRIVE);
	assign is_tick   = accept && (job_in.command == CMD_TICK);
	assign insert    = is_arrive && !full && (dur != '0);
	assign run       = is_tick && !empty;
	assign pop       = run && (ent[0].rem == rem_t'(1));

	assign new_ent.id   = job_in.job_id;
	assign new_ent.user = job_in.user_id;
	assign new_ent.rem  = dur;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_row
		logic   l_keep, l_valid, r_valid;
		entry_t l_ent, r_ent;

		assign ctl[k].insert  = insert;
		assign ctl[k].pop     = pop;
		assign ctl[k].dec     = (k == 0) ? (run && !pop) : 1'b0;
		assign ctl[k].new_ent = new_ent;

		if (k == 0) begin : g_head
			assign l_keep  = 1'b1;
			assign l_valid = 1'b0;
			assign l_ent   = new_ent;
		end else begin : g_body
			assign l_keep  = keep[k-1];
			assign l_valid = valid[k-1];
			assign l_ent   = ent[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_ent   = new_ent;
		end else begin : g_mid
			assign r_valid = valid[k+1];
			assign r_ent   = ent[k+1];
		end

		srtf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[k]),
			.left_keep   (l_keep),
			.left_valid  (l_valid),
			.left_ent    (l_ent),
			.right_valid (r_valid),
			.right_ent   (r_ent),
			.valid       (valid[k]),
			.keep        (keep[k]),
			.ent         (ent[k])
		);
	end

	always_comb begin
		res_d = '0;
		if (is_arrive) begin
			res_d.overflow = full;
		end else begin
			res_d.tick_time = time_q;
			if (!empty) begin
				res_d.running_valid = 1'b1;
				res_d.running_job   = ent[0].id;
			end
			if (pop) begin
				res_d.finished_valid = 1'b1;
				res_d.finished_user  = ent[0].user;
				res_d.finish_time    = time_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			time_q      <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (is_tick) begin
				time_q <= time_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.running_valid  = res_q.running_valid;
	assign result_out.running_job    = res_q.running_job;
	assign result_out.tick_time      = res_q.tick_time;
	assign result_out.finished_valid = res_q.finished_valid;
	assign result_out.finished_user  = res_q.finished_user;
	assign result_out.finish_time    = res_q.finish_time;
	assign result_out.overflow       = res_q.overflow;
endmodule

// ----- hw/rtl/srtf_checker.sv -----
`include "assert_macros.svh"

module srtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        running_valid,
	input logic [31:0] tick_time,
	input logic        finished_valid,
	input logic [31:0] finish_time,
	input logic        overflow
);
	// a stalled result stays valid and keeps its tick and finish times
	`SRTF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(finish_time) && $stable(tick_time))

	// every input transfer yields a result in the next cycle
	`SRTF_ASSERT_NEXT(a_result, in_valid && in_ready, out_valid)

	// only a running job can finish
	`SRTF_ASSERT_IMP(a_fin_run, out_valid && finished_valid, running_valid)

	// finish time is one past the tick time
	`SRTF_ASSERT_IMP(a_fin_time, out_valid && finished_valid, finish_time == tick_time + 32'd1)

	// a dropped arrival never reports a running or finished job
	`SRTF_ASSERT_IMP(a_ovf, out_valid && overflow, !running_valid && !finished_valid)
endmodule

bind shortest_remaining_time_scheduler_top srtf_checker u_srtf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (job_in.valid),
	.in_ready       (job_in.ready),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.running_valid  (result_out.running_valid),
	.tick_time      (result_out.tick_time),
	.finished_valid (result_out.finished_valid),
	.finish_time    (result_out.finish_time),
	.overflow       (result_out.overflow)
);
